>>> src/life_automaton_stencil_assert.svh
// assertion helpers, clocked on clk, disabled while arst_n is low
`ifndef LIFE_AUTOMATON_STENCIL_ASSERT_SVH
`define LIFE_AUTOMATON_STENCIL_ASSERT_SVH

`define LAS_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define LAS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define LAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/las_pkg.sv
package las_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int CFG_W          = 11;
	localparam int CFG_RESET      = 1024;
	localparam int COORD_W        = 10;
	localparam int APB_AW         = 3;
	localparam int APB_DW         = 32;
	localparam int BIRTH_N        = 3;
	localparam int SURVIVE_N      = 2;

	localparam logic MODE_DRAIN = 1'b1;

	typedef enum logic {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic mode;
		logic cell_alive;
	} cell_word_t;

	typedef struct packed {
		logic               next_alive;
		logic [COORD_W-1:0] out_row;
		logic [COORD_W-1:0] out_col;
		logic               frame_last;
	} res_word_t;

	typedef struct packed {
		logic left_ok;
		logic right_ok;
		logic top_ok;
		logic bot_ok;
	} nbr_mask_t;

	// bit 0 top row, bit 2 bottom row
	typedef logic [2:0] col_slice_t;

endpackage

>>> src/life_automaton_stencil.sv
// Pipeline: a word accepted at one edge waits in the pipeline register; when it
// advances, its result enters the output register and res_valid rises. A result
// belongs to the input word grid_width+1 positions earlier.
// Throughput: one word per cycle, set by the one-read one-write line buffer and the
// 3-cell window chain; a held result stalls input. Reset: counters, window and output
// valid clear; line buffer contents are left as is.
`include "life_automaton_stencil_assert.svh"

module life_automaton_stencil import las_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cell_valid,
	output logic              cell_ready,
	input  cell_word_t        cell_word,
	output logic              res_valid,
	input  logic              res_ready,
	output res_word_t         res_word,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int W_RST = (CFG_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET;
	localparam int H_RST = (CFG_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET;

	// config
	logic [CFG_W-1:0] gw_q, gh_q;
	logic [COL_W-1:0] w_lim_q, w_lim_new;
	logic [ROW_W-1:0] h_lim_q, h_lim_new;
	logic             cfg_wr;
	reg_idx_t         reg_idx;

	// input side counters
	logic [COL_W-1:0] col_q;
	logic [1:0]       rows_q;
	logic [COL_W-1:0] oc_q;
	logic [ROW_W-1:0] or_q;

	// s1
	logic             s1_valid_q;
	logic             v_s1, emit_s1, last_s1;
	logic [COL_W-1:0] col_s1, ocol_s1;
	logic [ROW_W-1:0] orow_s1;
	nbr_mask_t        mask_s1;
	logic             byp_s1, byp_up_s1, byp_mid_s1;

	logic             acc, s1_adv, v_in, emit_in, last_in, col_end;
	nbr_mask_t        mask_in;
	logic [1:0]       rd_data;
	logic             up_eff, mid_eff;
	col_slice_t       new_col;
	col_slice_t       win_col [3];
	col_slice_t       cell_d  [3];
	logic             win_clear, nxt;

	res_word_t        res_q;
	logic             res_valid_q;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		if (pwdata[CFG_W-1:0] == '0) begin
			w_lim_new = '0;
		end else if (32'(pwdata[CFG_W-1:0]) > MAX_WIDTH) begin
			w_lim_new = COL_W'(MAX_WIDTH - 1);
		end else begin
			w_lim_new = COL_W'(32'(pwdata[CFG_W-1:0]) - 32'd1);
		end
		if (pwdata[CFG_W-1:0] == '0) begin
			h_lim_new = '0;
		end else if (32'(pwdata[CFG_W-1:0]) > MAX_HEIGHT) begin
			h_lim_new = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			h_lim_new = ROW_W'(32'(pwdata[CFG_W-1:0]) - 32'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q    <= CFG_W'(CFG_RESET);
			gh_q    <= CFG_W'(CFG_RESET);
			w_lim_q <= COL_W'(W_RST - 1);
			h_lim_q <= ROW_W'(H_RST - 1);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_GRID_WIDTH: begin
					gw_q    <= pwdata[CFG_W-1:0];
					w_lim_q <= w_lim_new;
				end
				REG_GRID_HEIGHT: begin
					gh_q    <= pwdata[CFG_W-1:0];
					h_lim_q <= h_lim_new;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_GRID_WIDTH:  prdata = APB_DW'(gw_q);
			REG_GRID_HEIGHT: prdata = APB_DW'(gh_q);
			default:         prdata = '0;
		endcase
	end

	// accept side
	assign s1_adv     = s1_valid_q && (!emit_s1 || !res_valid_q || res_ready);
	assign cell_ready = !s1_valid_q || s1_adv;
	assign acc        = cell_valid && cell_ready;

	always_comb begin
		v_in             = (cell_word.mode == MODE_DRAIN) ? 1'b0 : cell_word.cell_alive;
		emit_in          = (rows_q == 2'd2) || ((rows_q == 2'd1) && (col_q != '0));
		col_end          = (col_q == w_lim_q);
		mask_in.left_ok  = (oc_q != '0);
		mask_in.right_ok = (oc_q != w_lim_q);
		mask_in.top_ok   = (or_q != '0);
		mask_in.bot_ok   = (or_q != h_lim_q);
		last_in          = emit_in && !mask_in.right_ok && !mask_in.bot_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			rows_q <= '0;
			oc_q   <= '0;
			or_q   <= '0;
		end else if (cfg_wr || (acc && last_in)) begin
			col_q  <= '0;
			rows_q <= '0;
			oc_q   <= '0;
			or_q   <= '0;
		end else if (acc) begin
			col_q <= col_end ? '0 : col_q + 1'b1;
			if (col_end && (rows_q != 2'd2)) begin
				rows_q <= rows_q + 2'd1;
			end
			if (emit_in) begin
				oc_q <= mask_in.right_ok ? oc_q + 1'b1 : '0;
				if (!mask_in.right_ok) begin
					or_q <= or_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			v_s1       <= v_in;
			col_s1     <= col_q;
			emit_s1    <= emit_in;
			last_s1    <= last_in;
			mask_s1    <= mask_in;
			orow_s1    <= or_q;
			ocol_s1    <= oc_q;
			// same column written at this edge: take what is being written
			byp_s1     <= s1_adv && (col_s1 == col_q);
			byp_up_s1  <= mid_eff;
			byp_mid_s1 <= v_s1;
		end
	end

	las_line_buf #(
		.DEPTH(MAX_WIDTH),
		.AW   (COL_W)
	) u_line_buf (
		.clk    (clk),
		.rd_en  (acc),
		.rd_addr(col_q),
		.rd_data(rd_data),
		.wr_en  (s1_adv),
		.wr_addr(col_s1),
		.wr_data({mid_eff, v_s1})
	);

	assign up_eff  = byp_s1 ? byp_up_s1  : rd_data[1];
	assign mid_eff = byp_s1 ? byp_mid_s1 : rd_data[0];
	assign new_col = {v_s1, mid_eff, up_eff};

	// window: cell 0 left, cell 2 right, new column enters at the right
	assign win_clear = cfg_wr || (s1_adv && last_s1);

	for (genvar i = 0; i < 3; i++) begin : g_win
		if (i == 2) begin : g_tail
			assign cell_d[i] = new_col;
		end else begin : g_link
			assign cell_d[i] = win_col[i+1];
		end
		las_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift_en(s1_adv),
			.clear   (win_clear),
			.d       (cell_d[i]),
			.q       (win_col[i])
		);
	end

	las_rule u_rule (
		.left      (win_col[1]),
		.centre    (win_col[2]),
		.right     (new_col),
		.mask      (mask_s1),
		.next_alive(nxt)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			res_q.next_alive <= nxt;
			res_q.out_row    <= COORD_W'(orow_s1);
			res_q.out_col    <= COORD_W'(ocol_s1);
			res_q.frame_last <= last_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

	`LAS_ASSERT_NEXT(a_win_clear, s1_adv && last_s1, (win_col[0] == '0) && (win_col[1] == '0) && (win_col[2] == '0), "window not cleared after last word")
	`LAS_ASSERT_IMPL(a_res_src, $rose(res_valid_q), $past(s1_adv && emit_s1), "result without emitting word")
	`LAS_ASSERT_ALWAYS(a_col_bound, col_q <= w_lim_q, "input column past row end")

endmodule

>>> src/las_cell.sv
module las_cell import las_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift_en,
	input  logic       clear,
	input  col_slice_t d,
	output col_slice_t q
);

	col_slice_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (clear) begin
			col_q <= '0;
		end else if (shift_en) begin
			col_q <= d;
		end
	end

	assign q = col_q;

endmodule

>>> src/las_line_buf.sv
module las_line_buf import las_pkg::*; #(
	parameter int DEPTH = MAX_WIDTH_DEF,
	parameter int AW    = $clog2(MAX_WIDTH_DEF)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [1:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_data
);

	// bit 1 upper line, bit 0 middle line
	logic [1:0] mem [DEPTH];
	logic [1:0] rd_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	assign rd_data = rd_s1;

endmodule

>>> src/las_rule.sv
module las_rule import las_pkg::*; (
	input  col_slice_t left,
	input  col_slice_t centre,
	input  col_slice_t right,
	input  nbr_mask_t  mask,
	output logic       next_alive
);

	logic [2:0] row_m;
	logic [2:0] l_m, c_m, r_m;
	logic [3:0] n;

	always_comb begin
		row_m = {mask.bot_ok, 1'b1, mask.top_ok};
		l_m   = mask.left_ok ? (left & row_m) : 3'b000;
		c_m   = centre & row_m & 3'b101;
		r_m   = mask.right_ok ? (right & row_m) : 3'b000;
		n     = 4'($countones({l_m, c_m, r_m}));
		next_alive = (n == 4'(BIRTH_N)) || (centre[1] && (n == 4'(SURVIVE_N)));
	end

endmodule

>>> dv/life_automaton_stencil_chk.sv
module life_automaton_stencil_chk import las_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cell_valid,
	input  logic              cell_ready,
	input  cell_word_t        cell_word,
	input  logic              res_valid,
	input  logic              res_ready,
	input  res_word_t         res_word,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic [APB_DW-1:0] prdata,
	input  logic              pready,
	output int                errors,
	output int                pending
);

	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	bit               up_line [MAX_WIDTH_DEF];
	bit               mid_line [MAX_WIDTH_DEF];
	logic [8:0]       window;
	int unsigned      in_row, in_col, out_row, out_col;
	res_word_t        next_gen_q [$];
	int               err_cnt = 0;
	int               pend_cnt = 0;

	assign errors  = err_cnt;
	assign pending = pend_cnt;

	function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned mx);
		if (v < 1)
			return 1;
		if (v > mx)
			return mx;
		return v;
	endfunction

	function automatic void restart_frame();
		window  = '0;
		in_row  = 0;
		in_col  = 0;
		out_row = 0;
		out_col = 0;
	endfunction

	function automatic void advance_in(int unsigned col, int unsigned w);
		in_col = col + 1;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
	endfunction

	// window bit col*3+row: col 0 left, row 0 top
	function automatic bit next_gen(input cell_word_t wd, output res_word_t res);
		int unsigned w, h, col, n;
		bit          v, centre;
		w   = clamp_dim(width_reg, MAX_WIDTH_DEF);
		h   = clamp_dim(height_reg, MAX_HEIGHT_DEF);
		res = '0;
		v   = (wd.mode == MODE_DRAIN) ? 1'b0 : wd.cell_alive;
		col = (in_col >= w) ? 0 : in_col;
		window = {v, mid_line[col], up_line[col], window[8:3]};
		up_line[col]  = mid_line[col];
		mid_line[col] = v;
		if (!(in_row >= 2 || (in_row == 1 && col >= 1))) begin
			advance_in(col, w);
			return 1'b0;
		end
		n = 0;
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 3; k++) begin
				if (c == 0 && out_col == 0)
					continue;
				if (c == 2 && out_col + 1 >= w)
					continue;
				if (c == 1 && k == 1)
					continue;
				if (k == 0 && out_row == 0)
					continue;
				if (k == 2 && out_row + 1 >= h)
					continue;
				n += window[c*3+k];
			end
		end
		centre = window[4];
		res.next_alive = centre ? (n == SURVIVE_N || n == BIRTH_N) : (n == BIRTH_N);
		res.out_row    = out_row[COORD_W-1:0];
		res.out_col    = out_col[COORD_W-1:0];
		if (out_row + 1 >= h && out_col + 1 >= w) begin
			res.frame_last = 1'b1;
			restart_frame();
			return 1'b1;
		end
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
		end
		advance_in(col, w);
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_word_t        pred, want;
		reg_idx_t         idx;
		logic [CFG_W-1:0] rd_want;
		if (!arst_n) begin
			width_reg  = CFG_W'(CFG_RESET);
			height_reg = CFG_W'(CFG_RESET);
			restart_frame();
			next_gen_q.delete();
			pend_cnt = 0;
		end else begin
			idx = reg_idx_t'(paddr[APB_AW-1:2]);
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (idx == REG_GRID_WIDTH)
						width_reg = pwdata[CFG_W-1:0];
					else
						height_reg = pwdata[CFG_W-1:0];
					restart_frame();
				end else begin
					rd_want = (idx == REG_GRID_WIDTH) ? width_reg : height_reg;
					if (prdata !== APB_DW'(rd_want)) begin
						$display("%0t: %s read expected %0d actual %0d", $time, idx.name(),
							rd_want, prdata);
						err_cnt++;
					end
				end
			end
			if (res_valid && res_ready) begin
				if (next_gen_q.size() == 0) begin
					$display("%0t: unexpected result word, expected none actual %p", $time,
						res_word);
					err_cnt++;
				end else begin
					want = next_gen_q.pop_front();
					if (res_word.next_alive !== want.next_alive) begin
						$display("%0t: next_alive expected %0d actual %0d", $time,
							want.next_alive, res_word.next_alive);
						err_cnt++;
					end
					if (res_word.out_row !== want.out_row) begin
						$display("%0t: out_row expected %0d actual %0d", $time,
							want.out_row, res_word.out_row);
						err_cnt++;
					end
					if (res_word.out_col !== want.out_col) begin
						$display("%0t: out_col expected %0d actual %0d", $time,
							want.out_col, res_word.out_col);
						err_cnt++;
					end
					if (res_word.frame_last !== want.frame_last) begin
						$display("%0t: frame_last expected %0d actual %0d", $time,
							want.frame_last, res_word.frame_last);
						err_cnt++;
					end
				end
			end
			if (cell_valid && cell_ready) begin
				if (next_gen(cell_word, pred))
					next_gen_q.push_back(pred);
			end
			pend_cnt = next_gen_q.size();
		end
	end

endmodule

>>> dv/life_automaton_stencil_tb.sv
module life_automaton_stencil_tb import las_pkg::*;;

	localparam int   CYCLE_LIMIT = 600000;
	localparam logic MODE_CELL   = ~MODE_DRAIN;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cell_valid = 1'b0;
	logic              cell_ready;
	cell_word_t        cell_word = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	res_word_t         res_word;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	int                errors;
	int                pending;

	int cycles = 0;
	int burst_left = 0;
	int words_sent = 0;
	int stall_mode = 0;
	int stall_run = 0;

	life_automaton_stencil DUT (.*);

	life_automaton_stencil_chk chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: alternating stretches of always-ready, coin flips, long stalls and mostly-ready
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_run  = $urandom_range(20, 200);
		end
		stall_run--;
		case (stall_mode)
			0: res_ready <= 1'b1;
			1: res_ready <= 1'($urandom_range(0, 1));
			2: res_ready <= ($urandom_range(0, 11) == 0);
			default: res_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	function automatic int clamp_dim(int v, int mx);
		if (v < 1)
			return 1;
		if (v > mx)
			return mx;
		return v;
	endfunction

	function automatic cell_word_t mk(logic m, logic c);
		cell_word_t wd;
		wd.mode       = m;
		wd.cell_alive = c;
		return wd;
	endfunction

	// called and returns at a falling edge; valid stays high between back-to-back words
	task automatic send_word(cell_word_t wd);
		if (burst_left == 0) begin
			cell_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) :
				$urandom_range(1, 20);
		end
		burst_left--;
		cell_valid <= 1'b1;
		cell_word  <= wd;
		do
			@(posedge clk);
		while (!cell_ready);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic apb_xfer(bit wr, reg_idx_t idx, logic [APB_DW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= APB_AW'(idx) << 2;
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		cell_valid <= 1'b0;
		burst_left = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_grid(int wr, int hr);
		drain_results();
		apb_xfer(1'b1, REG_GRID_WIDTH, wr);
		apb_xfer(1'b1, REG_GRID_HEIGHT, hr);
		apb_xfer(1'b0, REG_GRID_WIDTH, '0);
		apb_xfer(1'b0, REG_GRID_HEIGHT, '0);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// noisy frames slip in early drain words and cell words among the drain words
	task automatic send_frame(int w, int h, bit noisy);
		int dens;
		dens = 10 + 20 * $urandom_range(0, 3);
		for (int i = 0; i < w * h; i++)
			send_word(mk((noisy && $urandom_range(0, 15) == 0) ? MODE_DRAIN : MODE_CELL,
				$urandom_range(0, 99) < dens));
		for (int j = 0; j <= w; j++)
			send_word(mk((noisy && $urandom_range(0, 7) == 0) ? MODE_CELL : MODE_DRAIN,
				1'($urandom_range(0, 1))));
	endtask

	task automatic run_phase(int wr, int hr, int frames, bit noisy, int tail);
		set_grid(wr, hr);
		repeat (frames)
			send_frame(clamp_dim(wr, MAX_WIDTH_DEF), clamp_dim(hr, MAX_HEIGHT_DEF), noisy);
		repeat (tail)
			send_word(mk(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
	endtask

	initial begin
		int start, wr, hr, sel;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		apb_xfer(1'b0, REG_GRID_WIDTH, '0);
		apb_xfer(1'b0, REG_GRID_HEIGHT, '0);
		psel    <= 1'b0;
		penable <= 1'b0;

		// vertical blinker, first cell sent as an early drain word carrying a live bit
		set_grid(3, 3);
		for (int i = 0; i < 9; i++)
			send_word((i == 0) ? mk(MODE_DRAIN, 1'b1) : mk(MODE_CELL, (i % 3) == 1));
		for (int j = 0; j < 4; j++)
			send_word(mk(MODE_DRAIN, 1'(j % 2)));
		set_grid(1, 1);
		send_word(mk(MODE_CELL, 1'b1));
		send_word(mk(MODE_DRAIN, 1'b1));
		send_word(mk(MODE_DRAIN, 1'b0));
		// 2x2 block is a still life
		set_grid(2, 2);
		repeat (4) send_word(mk(MODE_CELL, 1'b1));
		repeat (3) send_word(mk(MODE_DRAIN, 1'b0));

		run_phase(2047, 0, 0, 1'b0, 120);
		run_phase(1, 2047, 0, 1'b0, 120);
		run_phase(1024, 2047, 0, 1'b0, 30);

		start = words_sent;
		while (words_sent - start < 1100) begin
			sel = $urandom_range(0, 9);
			wr  = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(13, 48) : $urandom_range(1, 12);
			hr  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
			run_phase(wr, hr, $urandom_range(1, 3), $urandom_range(0, 3) == 0,
				($urandom_range(0, 6) == 0) ? $urandom_range(1, 60) : 0);
		end

		cell_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/las_pkg.sv
src/las_cell.sv
src/las_line_buf.sv
src/las_rule.sv
src/life_automaton_stencil.sv
dv/life_automaton_stencil_chk.sv
dv/life_automaton_stencil_tb.sv
